>>> rtl/core/ftss_pkg.sv
// Shared constants and types for the five-track step trigger sequencer.
`timescale 1ns / 1ps

package ftss_pkg;

    localparam int STEPS_DEFAULT  = 16;
    localparam int TRACKS_DEFAULT = 5;

    localparam int BUTTONS  = 80;
    localparam int HALF_W   = 40;
    localparam int STEP_W   = 4;
    localparam int GATE_W   = 5;
    localparam int PULSE_W  = 8;
    localparam int DELAY_W  = 16;
    localparam int CFG_W    = 16;

    localparam logic [PULSE_W-1:0] PULSE_RESET = 8'd20;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd20000;

    typedef enum logic [0:0] {
        CFG_PULSE_LENGTH      = 1'b0,
        CFG_HOLD_REPEAT_DELAY = 1'b1
    } cfg_index_t;

endpackage

>>> rtl/core/five_track_step_trigger_sequencer_core.sv
// Step trigger sequencer core: pattern grid, step position, edit mode and trigger pulses.
// Path: an accepted request is held in the input register and moves on to the result register
// once the result slot is free; its result stays valid there until it is taken.
// Throughput: one request per cycle; while a result waits on a stalled output the input
// register takes one more request and then stalls the input.
// Reset clears all sequencer state and loads pulse length 20 and hold delay 20000.
`timescale 1ns / 1ps

module five_track_step_trigger_sequencer_core #(
    parameter int STEPS  = ftss_pkg::STEPS_DEFAULT,
    parameter int TRACKS = ftss_pkg::TRACKS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ftss_pkg::CFG_W-1:0]    cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          reset_level,
    input  logic                          advance_level,
    input  logic                          edit_button,
    input  logic [ftss_pkg::HALF_W-1:0]   buttons_low,
    input  logic [ftss_pkg::HALF_W-1:0]   buttons_high,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ftss_pkg::GATE_W-1:0]   trigger_gates,
    output logic                          edit_lamp,
    output logic [ftss_pkg::HALF_W-1:0]   lights_low,
    output logic [ftss_pkg::HALF_W-1:0]   lights_high,
    output logic [ftss_pkg::STEP_W-1:0]   step_now
);

    localparam int CELLS = STEPS * TRACKS;
    localparam int SH_W  = $clog2(CELLS + 1);

    // Configuration registers.
    logic [ftss_pkg::PULSE_W-1:0] pulse_len_reg;
    logic [ftss_pkg::DELAY_W-1:0] hold_delay_reg;

    // Input register.
    logic                          ir_valid_reg;
    logic                          ir_reset_reg;
    logic                          ir_advance_reg;
    logic                          ir_edit_reg;
    logic [ftss_pkg::BUTTONS-1:0]  ir_buttons_reg;

    // Sequencer state.
    logic [CELLS-1:0]              pattern_reg;
    logic [CELLS-1:0]              pattern_next;
    logic [ftss_pkg::STEP_W-1:0]   pos_reg;
    logic [ftss_pkg::STEP_W-1:0]   pos_next;
    logic                          edit_reg;
    logic                          edit_next;
    logic [ftss_pkg::DELAY_W-1:0]  lock_reg;
    logic [ftss_pkg::DELAY_W-1:0]  lock_next;
    logic [ftss_pkg::PULSE_W-1:0]  cnt_reg  [TRACKS];
    logic [ftss_pkg::PULSE_W-1:0]  cnt_next [TRACKS];
    logic                          last_rst_reg;
    logic                          last_adv_reg;
    logic                          last_edit_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [ftss_pkg::GATE_W-1:0]   gates_reg;
    logic                          edit_lamp_reg;
    logic [ftss_pkg::BUTTONS-1:0]  lights_reg;
    logic [ftss_pkg::STEP_W-1:0]   step_reg;

    logic                          proc;
    logic                          accept;
    logic                          rst_edge;
    logic                          adv_edge;
    logic                          edit_edge;
    logic [ftss_pkg::STEP_W-1:0]   pos_a;
    logic [SH_W-1:0]               row_shift;
    logic [SH_W-1:0]               view_shift;
    logic [CELLS-1:0]              row_window;
    logic [TRACKS-1:0]             row_bits;
    logic [2*CELLS-1:0]            lights_rot;
    logic [2*CELLS-1:0]            flip_rot;
    logic [CELLS-1:0]              held;
    logic [CELLS-1:0]              flip;
    logic [ftss_pkg::BUTTONS-1:0]  lights_c;
    logic [ftss_pkg::GATE_W-1:0]   gates_c;
    logic [ftss_pkg::PULSE_W-1:0]  cnt_load;

    // A request moves from the input register to the result register when the
    // result slot is empty or being emptied in this cycle.
    assign proc     = ir_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = ir_valid_reg && !proc;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        rst_edge  = ir_reset_reg && !last_rst_reg;
        adv_edge  = ir_advance_reg && !last_adv_reg;
        edit_edge = ir_edit_reg && !last_edit_reg;

        pos_a      = rst_edge ? '0 : pos_reg;
        row_shift  = SH_W'(pos_a) * SH_W'(TRACKS);
        row_window = pattern_reg >> row_shift;
        row_bits   = row_window[TRACKS-1:0];

        if (adv_edge)
        begin
            pos_next = (pos_a == ftss_pkg::STEP_W'(STEPS - 1)) ? '0 : pos_a + 1'b1;
        end
        else
        begin
            pos_next = pos_a;
        end

        edit_next  = edit_reg ^ edit_edge;
        view_shift = edit_next ? '0 : SH_W'(pos_next) * SH_W'(TRACKS);

        // Button i addresses cell (i + shift) mod CELLS: the lights are the
        // pattern rotated down by the shift, the toggles are the held buttons
        // rotated up by it.
        lights_rot = {pattern_reg, pattern_reg} >> view_shift;
        lights_c   = ftss_pkg::BUTTONS'(lights_rot[CELLS-1:0]);

        held     = ir_buttons_reg[CELLS-1:0];
        flip_rot = {held, held} >> (SH_W'(CELLS) - view_shift);
        flip     = flip_rot[CELLS-1:0];

        if (lock_reg == '0)
        begin
            pattern_next = pattern_reg ^ flip;
            lock_next    = (|held) ? hold_delay_reg : '0;
        end
        else
        begin
            pattern_next = pattern_reg;
            lock_next    = lock_reg - 1'b1;
        end

        gates_c  = '0;
        cnt_load = '0;
        for (int t = 0; t < TRACKS; t++)
        begin
            cnt_load    = (adv_edge && row_bits[t]) ? pulse_len_reg : cnt_reg[t];
            gates_c[t]  = (cnt_load != '0);
            cnt_next[t] = gates_c[t] ? cnt_load - 1'b1 : cnt_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_len_reg  <= ftss_pkg::PULSE_RESET;
            hold_delay_reg <= ftss_pkg::DELAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ftss_pkg::CFG_PULSE_LENGTH:
                    pulse_len_reg  <= cfg_data[ftss_pkg::PULSE_W-1:0];
                ftss_pkg::CFG_HOLD_REPEAT_DELAY:
                    hold_delay_reg <= cfg_data[ftss_pkg::DELAY_W-1:0];
                default:
                    pulse_len_reg  <= pulse_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            ir_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            ir_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ir_reset_reg   <= reset_level;
            ir_advance_reg <= advance_level;
            ir_edit_reg    <= edit_button;
            ir_buttons_reg <= {buttons_high, buttons_low};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= '0;
            pos_reg       <= '0;
            edit_reg      <= 1'b0;
            lock_reg      <= '0;
            last_rst_reg  <= 1'b0;
            last_adv_reg  <= 1'b0;
            last_edit_reg <= 1'b0;
            for (int t = 0; t < TRACKS; t++)
            begin
                cnt_reg[t] <= '0;
            end
        end
        else if (proc)
        begin
            pattern_reg   <= pattern_next;
            pos_reg       <= pos_next;
            edit_reg      <= edit_next;
            lock_reg      <= lock_next;
            last_rst_reg  <= ir_reset_reg;
            last_adv_reg  <= ir_advance_reg;
            last_edit_reg <= ir_edit_reg;
            for (int t = 0; t < TRACKS; t++)
            begin
                cnt_reg[t] <= cnt_next[t];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            gates_reg     <= gates_c;
            edit_lamp_reg <= edit_next;
            lights_reg    <= lights_c;
            step_reg      <= pos_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_gates = gates_reg;
    assign edit_lamp     = edit_lamp_reg;
    assign lights_low    = lights_reg[ftss_pkg::HALF_W-1:0];
    assign lights_high   = lights_reg[ftss_pkg::BUTTONS-1:ftss_pkg::HALF_W];
    assign step_now      = step_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= ftss_pkg::STEP_W'(STEPS - 1))
        else $error("step position beyond last step");

    a_lockout_freezes_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && lock_reg != '0) |=>
            (lock_reg == $past(lock_reg) - 1'b1) && $stable(pattern_reg))
        else $error("lockout did not count down or pattern changed during lockout");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> $stable(pattern_reg) && $stable(pos_reg) && $stable(lock_reg))
        else $error("sequencer state changed without a request");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_valid_reg && (step_reg == pos_reg) && (edit_lamp_reg == edit_reg))
        else $error("result register out of step with sequencer state");

endmodule

>>> tb/sv/five_track_step_trigger_sequencer_core_tb.sv
// Self-checking testbench for the five-track step trigger sequencer core.
`timescale 1ns / 1ps

module five_track_step_trigger_sequencer_core_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [ftss_pkg::GATE_W-1:0] gates;
        logic                        edit;
        logic [ftss_pkg::HALF_W-1:0] lo;
        logic [ftss_pkg::HALF_W-1:0] hi;
        logic [ftss_pkg::STEP_W-1:0] step;
    } tick_result_t;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        cfg_we        = 1'b0;
    logic                        cfg_index     = 1'b0;
    logic [ftss_pkg::CFG_W-1:0]  cfg_data      = '0;
    logic                        in_valid      = 1'b0;
    logic                        in_stall;
    logic                        reset_level   = 1'b0;
    logic                        advance_level = 1'b0;
    logic                        edit_button   = 1'b0;
    logic [ftss_pkg::HALF_W-1:0] buttons_low   = '0;
    logic [ftss_pkg::HALF_W-1:0] buttons_high  = '0;
    logic                        out_valid;
    logic                        out_stall     = 1'b0;
    logic [ftss_pkg::GATE_W-1:0] trigger_gates;
    logic                        edit_lamp;
    logic [ftss_pkg::HALF_W-1:0] lights_low;
    logic [ftss_pkg::HALF_W-1:0] lights_high;
    logic [ftss_pkg::STEP_W-1:0] step_now;

    // Predicted sequencer state and register copies.
    logic [ftss_pkg::GATE_W-1:0]  pattern [ftss_pkg::STEPS_DEFAULT];
    logic [ftss_pkg::STEP_W-1:0]  step_pos;
    logic                         edit_on;
    logic [ftss_pkg::DELAY_W-1:0] lockout;
    logic [ftss_pkg::PULSE_W-1:0] pulse_cnt [ftss_pkg::TRACKS_DEFAULT];
    logic                         prev_rst;
    logic                         prev_adv;
    logic                         prev_edit;
    logic [ftss_pkg::PULSE_W-1:0] cfg_pulse;
    logic [ftss_pkg::DELAY_W-1:0] cfg_hold;

    tick_result_t expected_ticks [$];
    int           error_count = 0;
    int           cycles      = 0;
    int           stall_left  = 0;
    bit           idle_en     = 1'b1;
    logic         lvl_rst     = 1'b0;
    logic         lvl_adv     = 1'b0;
    logic         lvl_edit    = 1'b0;

    five_track_step_trigger_sequencer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .reset_level   (reset_level),
        .advance_level (advance_level),
        .edit_button   (edit_button),
        .buttons_low   (buttons_low),
        .buttons_high  (buttons_high),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .trigger_gates (trigger_gates),
        .edit_lamp     (edit_lamp),
        .lights_low    (lights_low),
        .lights_high   (lights_high),
        .step_now      (step_now)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic flag_error(string msg);
        error_count++;
        $display("ERROR cycle %0d: %s", cycles, msg);
    endtask

    task automatic check_field(string name, logic [ftss_pkg::HALF_W-1:0] got,
                               logic [ftss_pkg::HALF_W-1:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Button i maps to a cell rotated by the step position unless editing.
    function automatic int view_cell(int i);
        if (edit_on)
            return i;
        return (i + step_pos * ftss_pkg::TRACKS_DEFAULT) % ftss_pkg::BUTTONS;
    endfunction

    function automatic tick_result_t predict_tick(logic r, logic a, logic e,
                                                  logic [ftss_pkg::HALF_W-1:0] bl,
                                                  logic [ftss_pkg::HALF_W-1:0] bh);
        tick_result_t                 res;
        logic [ftss_pkg::BUTTONS-1:0] held;
        logic [ftss_pkg::BUTTONS-1:0] lit;
        int                           c;
        res  = '0;
        held = {bh, bl};
        if (r && !prev_rst)
            step_pos = '0;
        prev_rst = r;
        if (a && !prev_adv)
        begin
            for (int t = 0; t < ftss_pkg::TRACKS_DEFAULT; t++)
                if (pattern[step_pos][t])
                    pulse_cnt[t] = cfg_pulse;
            step_pos = (step_pos == ftss_pkg::STEP_W'(ftss_pkg::STEPS_DEFAULT - 1)) ?
                       '0 : step_pos + 1'b1;
        end
        prev_adv = a;
        if (e && !prev_edit)
            edit_on = ~edit_on;
        prev_edit = e;
        // Lights show the pattern before this tick's toggles.
        for (int i = 0; i < ftss_pkg::BUTTONS; i++)
        begin
            c = view_cell(i);
            lit[i] = pattern[c / ftss_pkg::TRACKS_DEFAULT][c % ftss_pkg::TRACKS_DEFAULT];
        end
        if (lockout == 0)
        begin
            for (int i = 0; i < ftss_pkg::BUTTONS; i++)
                if (held[i])
                begin
                    c = view_cell(i);
                    pattern[c / ftss_pkg::TRACKS_DEFAULT][c % ftss_pkg::TRACKS_DEFAULT] =
                        ~pattern[c / ftss_pkg::TRACKS_DEFAULT][c % ftss_pkg::TRACKS_DEFAULT];
                    lockout = cfg_hold;
                end
        end
        else
            lockout = lockout - 1'b1;
        for (int t = 0; t < ftss_pkg::TRACKS_DEFAULT; t++)
            if (pulse_cnt[t] != 0)
            begin
                pulse_cnt[t] = pulse_cnt[t] - 1'b1;
                res.gates[t] = 1'b1;
            end
        res.edit = edit_on;
        res.lo   = lit[ftss_pkg::HALF_W-1:0];
        res.hi   = lit[ftss_pkg::BUTTONS-1:ftss_pkg::HALF_W];
        res.step = step_pos;
        return res;
    endfunction

    function automatic logic [ftss_pkg::HALF_W-1:0] rand40();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ftss_pkg::HALF_W-1:0];
    endfunction

    task automatic send_tick(logic r, logic a, logic e,
                             logic [ftss_pkg::HALF_W-1:0] bl,
                             logic [ftss_pkg::HALF_W-1:0] bh);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        reset_level   <= r;
        advance_level <= a;
        edit_button   <= e;
        buttons_low   <= bl;
        buttons_high  <= bh;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_ticks.push_back(predict_tick(r, a, e, bl, bh));
    endtask

    // Waits until every request has its result, so registers can be written.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(ftss_pkg::cfg_index_t idx, logic [ftss_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ftss_pkg::CFG_PULSE_LENGTH:      cfg_pulse = value[ftss_pkg::PULSE_W-1:0];
            ftss_pkg::CFG_HOLD_REPEAT_DELAY: cfg_hold  = value;
            default:                         cfg_pulse = cfg_pulse;
        endcase
        @(posedge clk);
    endtask

    task automatic send_random_tick();
        logic [ftss_pkg::HALF_W-1:0] bl;
        logic [ftss_pkg::HALF_W-1:0] bh;
        int                          pick;
        if ($urandom_range(0, 19) == 0)
            lvl_rst = ~lvl_rst;
        if ($urandom_range(0, 2) == 0)
            lvl_adv = ~lvl_adv;
        if ($urandom_range(0, 11) == 0)
            lvl_edit = ~lvl_edit;
        bl   = '0;
        bh   = '0;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            if ($urandom_range(0, 1) == 0)
                bl[$urandom_range(0, ftss_pkg::HALF_W - 1)] = 1'b1;
            else
                bh[$urandom_range(0, ftss_pkg::HALF_W - 1)] = 1'b1;
        end
        else if (pick < 35)
        begin
            bl = rand40() & rand40() & rand40();
            bh = rand40() & rand40() & rand40();
        end
        else if (pick < 40)
        begin
            bl = rand40();
            bh = rand40();
        end
        send_tick(lvl_rst, lvl_adv, lvl_edit, bl, bh);
    endtask

    task automatic test_grid_and_edges();
        logic [ftss_pkg::HALF_W-1:0] top_bit;
        logic [ftss_pkg::HALF_W-1:0] low_bit;
        top_bit = ftss_pkg::HALF_W'(1) << (ftss_pkg::HALF_W - 1);
        low_bit = ftss_pkg::HALF_W'(1);
        // With no hold delay every held button toggles on every tick.
        write_reg(ftss_pkg::CFG_HOLD_REPEAT_DELAY, '0);
        send_tick(1'b0, 1'b0, 1'b0, '1, '1);
        send_tick(1'b0, 1'b1, 1'b0, '0, '0);
        send_tick(1'b1, 1'b0, 1'b0, '0, '0);
        send_tick(1'b0, 1'b0, 1'b0, '0, top_bit);
        // Reset and advance edges together fire row zero and land on step one.
        send_tick(1'b1, 1'b1, 1'b0, '0, '0);
        send_tick(1'b1, 1'b0, 1'b1, low_bit, top_bit);
        send_tick(1'b0, 1'b0, 1'b0, '0, '1);
        send_tick(1'b0, 1'b0, 1'b1, top_bit, '0);
        send_tick(1'b0, 1'b1, 1'b0, '0, '0);
        send_tick(1'b0, 1'b0, 1'b0, '0, '0);
        send_tick(1'b0, 1'b1, 1'b0, '1, '0);
        send_tick(1'b0, 1'b0, 1'b0, '0, '0);
    endtask

    task automatic test_register_extremes();
        settle();
        write_reg(ftss_pkg::CFG_PULSE_LENGTH, '0);
        write_reg(ftss_pkg::CFG_HOLD_REPEAT_DELAY, 16'd3);
        // A zero pulse length never raises a gate.
        send_tick(1'b0, 1'b1, 1'b0, '0, '0);
        send_tick(1'b0, 1'b0, 1'b0, ftss_pkg::HALF_W'(5), '0);
        send_tick(1'b0, 1'b0, 1'b0, ftss_pkg::HALF_W'(5), '0);
        send_tick(1'b0, 1'b0, 1'b0, ftss_pkg::HALF_W'(5), '0);
        send_tick(1'b0, 1'b0, 1'b0, ftss_pkg::HALF_W'(5), '0);
        send_tick(1'b0, 1'b0, 1'b0, ftss_pkg::HALF_W'(5), '0);
        settle();
        write_reg(ftss_pkg::CFG_PULSE_LENGTH, 16'd255);
        write_reg(ftss_pkg::CFG_HOLD_REPEAT_DELAY, 16'hFFFF);
        send_tick(1'b0, 1'b1, 1'b0, '0, '0);
        send_tick(1'b0, 1'b0, 1'b0, '0, '0);
        send_tick(1'b0, 1'b1, 1'b0, '0, '0);
        send_tick(1'b0, 1'b0, 1'b0, '0, '0);
        lvl_rst  = 1'b0;
        lvl_adv  = 1'b0;
        lvl_edit = 1'b0;
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 8; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    write_reg(ftss_pkg::CFG_PULSE_LENGTH, 16'd1);
                    write_reg(ftss_pkg::CFG_HOLD_REPEAT_DELAY, 16'd0);
                end
                1:
                begin
                    write_reg(ftss_pkg::CFG_PULSE_LENGTH, 16'd255);
                    write_reg(ftss_pkg::CFG_HOLD_REPEAT_DELAY, 16'd1);
                end
                default:
                begin
                    write_reg(ftss_pkg::CFG_PULSE_LENGTH,
                              ftss_pkg::CFG_W'($urandom_range(1, 40)));
                    write_reg(ftss_pkg::CFG_HOLD_REPEAT_DELAY,
                              ftss_pkg::CFG_W'($urandom_range(0, 8)));
                end
            endcase
            repeat (170) send_random_tick();
        end
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        settle();
        write_reg(ftss_pkg::CFG_PULSE_LENGTH, ftss_pkg::CFG_W'(ftss_pkg::PULSE_RESET));
        write_reg(ftss_pkg::CFG_HOLD_REPEAT_DELAY, 16'hFFFF);
        repeat (140) send_random_tick();
    endtask

    always @(posedge clk)
    begin
        if (!idle_en)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ticks.size() == 0)
                flag_error("result with no request waiting");
            else
            begin
                want = expected_ticks.pop_front();
                check_field("trigger_gates", ftss_pkg::HALF_W'(trigger_gates),
                            ftss_pkg::HALF_W'(want.gates));
                check_field("edit_lamp", ftss_pkg::HALF_W'(edit_lamp),
                            ftss_pkg::HALF_W'(want.edit));
                check_field("lights_low", lights_low, want.lo);
                check_field("lights_high", lights_high, want.hi);
                check_field("step_now", ftss_pkg::HALF_W'(step_now),
                            ftss_pkg::HALF_W'(want.step));
            end
        end
    end

    initial
    begin
        for (int i = 0; i < ftss_pkg::STEPS_DEFAULT; i++)
            pattern[i] = '0;
        for (int t = 0; t < ftss_pkg::TRACKS_DEFAULT; t++)
            pulse_cnt[t] = '0;
        step_pos  = '0;
        edit_on   = 1'b0;
        lockout   = '0;
        prev_rst  = 1'b0;
        prev_adv  = 1'b0;
        prev_edit = 1'b0;
        cfg_pulse = ftss_pkg::PULSE_RESET;
        cfg_hold  = ftss_pkg::DELAY_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_grid_and_edges();
        test_register_extremes();
        test_random_phases();
        test_steady_stream();
        settle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ftss_pkg.sv
rtl/core/five_track_step_trigger_sequencer_core.sv
tb/sv/five_track_step_trigger_sequencer_core_tb.sv
